@@ src/rbp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbp_pkg: shared types, widths and saturating helpers
// Holds the controller-to-datapath command struct, the field widths and the
// saturating add and scale functions used by the refinement step.
// ----------------------------------------------------------------------------
package rbp_pkg;

  // Field widths
  localparam int unsigned CountW = 31;
  localparam int unsigned LevelW = 4;
  localparam int unsigned SatW   = 61;
  localparam int unsigned CfgIdxW = 1;

  // Saturation bound 2^61-1
  localparam logic [SatW-1:0] SatMax = {SatW{1'b1}};

  // Budget reset value
  localparam logic [SatW-1:0] BudgetReset = SatW'(64'd16777216);

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegVertexBudget = 1'b0;
  localparam logic [CfgIdxW-1:0] RegFaceBudget   = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;    // capture a new transaction
    logic step;    // advance the counts by one level
    logic finish;  // close the transaction and issue the result
  } rbp_cmd_t;

  // Saturating add; both operands are at most SatMax
  function automatic logic [SatW-1:0] sat_add(input logic [SatW-1:0] a,
                                              input logic [SatW-1:0] b);
    logic [SatW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[SatW] ? SatMax : sum[SatW-1:0];
  endfunction

  // Saturating scale by two
  function automatic logic [SatW-1:0] sat_x2(input logic [SatW-1:0] a);
    return a[SatW-1] ? SatMax : {a[SatW-2:0], 1'b0};
  endfunction

  // Saturating scale by four
  function automatic logic [SatW-1:0] sat_x4(input logic [SatW-1:0] a);
    return (|a[SatW-1:SatW-2]) ? SatMax : {a[SatW-3:0], 2'b00};
  endfunction

  // Saturating scale by three: a + 2a
  function automatic logic [SatW-1:0] sat_x3(input logic [SatW-1:0] a);
    logic [SatW+1:0] sum;
    sum = {2'b00, a} + {1'b0, a, 1'b0};
    return (|sum[SatW+1:SatW]) ? SatMax : sum[SatW-1:0];
  endfunction

endpackage

@@ src/rbp_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbp_ctrl: transaction sequencer
// Accepts a query, clamps its level, counts one refinement level per cycle
// and closes the transaction with a finish command.
// ----------------------------------------------------------------------------
module rbp_ctrl #(
  parameter int unsigned MAX_LEVEL = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [rbp_pkg::LevelW-1:0]   level_i,
  output logic                         busy_o,
  output rbp_pkg::rbp_cmd_t            cmd_o
);

  localparam int unsigned CntW = $clog2(MAX_LEVEL + 1);
  localparam int unsigned CmpW = (CntW > rbp_pkg::LevelW) ? CntW : rbp_pkg::LevelW;

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StStep   = 2'd1;
  localparam logic [1:0] StFinish = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CmpW-1:0] level_ext, level_max, level_clamp;
  logic            accept;

  // Clamp the requested level to the supported depth
  assign level_ext   = CmpW'(level_i);
  assign level_max   = CmpW'(MAX_LEVEL);
  assign level_clamp = (level_ext > level_max) ? level_max : level_ext;

  assign busy_o = (state_q != StIdle);
  assign accept = start_i && !busy_o;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          cnt_d      = CntW'(level_clamp);
          state_d    = (level_clamp == '0) ? StFinish : StStep;
        end
      end
      StStep: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        cmd_o.finish = 1'b1;
        state_d      = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Hold state and level count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

@@ src/rbp_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbp_dp: refinement datapath
// Holds the running mesh counts, applies one saturating refinement level per
// step command and tracks whether every level stayed within both budgets.
// ----------------------------------------------------------------------------
module rbp_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rbp_pkg::rbp_cmd_t             cmd_i,
  input  logic                          scheme_is_triangle_i,
  input  logic [rbp_pkg::CountW-1:0]    vertex_count_i,
  input  logic [rbp_pkg::CountW-1:0]    edge_count_i,
  input  logic [rbp_pkg::CountW-1:0]    face_count_i,
  input  logic [rbp_pkg::CountW-1:0]    corner_total_i,
  input  logic [rbp_pkg::SatW-1:0]      vertex_budget_i,
  input  logic [rbp_pkg::SatW-1:0]      face_budget_i,
  output logic                          done_o,
  output logic                          fits_o
);

  logic                       tri_q;
  logic [rbp_pkg::SatW-1:0]   v_q, e_q, f_q, fv_q;
  logic [rbp_pkg::SatW-1:0]   v_d, e_d, f_d, fv_d;
  logic                       chk_q, ok_q, done_q, fits_q;
  logic                       in_budget;

  // One refinement level
  always_comb begin
    if (tri_q) begin
      v_d  = rbp_pkg::sat_add(v_q, e_q);
      e_d  = rbp_pkg::sat_add(rbp_pkg::sat_x2(e_q), rbp_pkg::sat_x3(f_q));
      f_d  = rbp_pkg::sat_x4(f_q);
      fv_d = rbp_pkg::sat_x3(f_d);
    end else begin
      v_d  = rbp_pkg::sat_add(rbp_pkg::sat_add(v_q, e_q), f_q);
      f_d  = fv_q;
      e_d  = rbp_pkg::sat_add(rbp_pkg::sat_x2(e_q), fv_q);
      fv_d = rbp_pkg::sat_x4(fv_q);
    end
  end

  // Budget check on the counts of the level just produced
  assign in_budget = (v_q <= vertex_budget_i) && (f_q <= face_budget_i);

  // Load or advance the counts
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      tri_q <= scheme_is_triangle_i;
      v_q   <= rbp_pkg::SatW'(vertex_count_i);
      e_q   <= rbp_pkg::SatW'(edge_count_i);
      f_q   <= rbp_pkg::SatW'(face_count_i);
      fv_q  <= rbp_pkg::SatW'(corner_total_i);
    end else if (cmd_i.step) begin
      v_q  <= v_d;
      e_q  <= e_d;
      f_q  <= f_d;
      fv_q <= fv_d;
    end
  end

  // Accumulate the verdict and issue the result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chk_q  <= 1'b0;
      ok_q   <= 1'b1;
      done_q <= 1'b0;
      fits_q <= 1'b0;
    end else begin
      chk_q  <= cmd_i.step;
      done_q <= cmd_i.finish;
      if (cmd_i.load) begin
        ok_q <= 1'b1;
      end else if (chk_q) begin
        ok_q <= ok_q && in_budget;
      end
      if (cmd_i.finish) begin
        fits_q <= ok_q && (!chk_q || in_budget);
      end
    end
  end

  assign done_o = done_q;
  assign fits_o = fits_q;

endmodule

@@ src/refinement_budget_predictor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refinement_budget_predictor: refined mesh size check against budgets
// Flow: after accept the sequencer issues N = min(level_i, MAX_LEVEL) steps and
// then a finish, from which done_o is registered; the step unit advances one
// level per cycle. One query at a time: busy is high from accept until the
// strobe, and a new start is taken in the cycle done_o is shown.
// Reset: both budgets return to 2^24 and the sequencer goes idle.
// The result is shown for one cycle on done_o; the receiver cannot stall.
// ----------------------------------------------------------------------------
module refinement_budget_predictor #(
  parameter int unsigned MAX_LEVEL = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic                           scheme_is_triangle_i,
  input  logic [rbp_pkg::CountW-1:0]     vertex_count_i,
  input  logic [rbp_pkg::CountW-1:0]     edge_count_i,
  input  logic [rbp_pkg::CountW-1:0]     face_count_i,
  input  logic [rbp_pkg::CountW-1:0]     corner_total_i,
  input  logic [rbp_pkg::LevelW-1:0]     level_i,
  output logic                           done_o,
  output logic                           fits_o,
  input  logic                           cfg_we_i,
  input  logic [rbp_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [rbp_pkg::SatW-1:0]       cfg_wdata_i
);

  logic [rbp_pkg::SatW-1:0] vertex_budget_q, face_budget_q;
  rbp_pkg::rbp_cmd_t        cmd;

  // Budget registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_budget_q <= rbp_pkg::BudgetReset;
      face_budget_q   <= rbp_pkg::BudgetReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        rbp_pkg::RegVertexBudget: vertex_budget_q <= cfg_wdata_i;
        rbp_pkg::RegFaceBudget:   face_budget_q   <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Sequencer
  rbp_ctrl #(
    .MAX_LEVEL(MAX_LEVEL)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .level_i(level_i),
    .busy_o (busy),
    .cmd_o  (cmd)
  );

  // Count datapath
  rbp_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .scheme_is_triangle_i(scheme_is_triangle_i),
    .vertex_count_i      (vertex_count_i),
    .edge_count_i        (edge_count_i),
    .face_count_i        (face_count_i),
    .corner_total_i      (corner_total_i),
    .vertex_budget_i     (vertex_budget_q),
    .face_budget_i       (face_budget_q),
    .done_o              (done_o),
    .fits_o              (fits_o)
  );

  // Accepted transaction keeps the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // Finish command produces exactly the following strobe
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o == $past(cmd.finish))
    else $error("result strobe out of step with finish command");

  // Sequencer is idle while the result is shown
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  // At most one command at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd))
    else $error("conflicting datapath commands");

endmodule

@@ tb/refinement_budget_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refinement_budget_checker: prediction and comparison for the budget check
// Watches the budget write port and the query and result channels, keeps
// its own copy of both budgets, works out the expected fits bit for every
// accepted query and compares each result strobe against the oldest one.
// ----------------------------------------------------------------------------
module refinement_budget_checker #(
  parameter int unsigned MAX_LEVEL = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  input  logic                        busy,
  input  logic                        scheme_is_triangle_i,
  input  logic [rbp_pkg::CountW-1:0]  vertex_count_i,
  input  logic [rbp_pkg::CountW-1:0]  edge_count_i,
  input  logic [rbp_pkg::CountW-1:0]  face_count_i,
  input  logic [rbp_pkg::CountW-1:0]  corner_total_i,
  input  logic [rbp_pkg::LevelW-1:0]  level_i,
  input  logic                        done_o,
  input  logic                        fits_o,
  input  logic                        cfg_we_i,
  input  logic [rbp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [rbp_pkg::SatW-1:0]    cfg_wdata_i,
  output int                          fail_count_o,
  output int                          pending_o
);

  logic [rbp_pkg::SatW-1:0] vertex_limit;
  logic [rbp_pkg::SatW-1:0] face_limit;
  logic                     fits_expected_q[$];
  int                       mismatches;
  int                       queued;

  assign fail_count_o = mismatches;
  assign pending_o    = queued;

  // Add two counts, clamp at the saturation bound
  function automatic logic [rbp_pkg::SatW-1:0] clamp_sum(
      input logic [rbp_pkg::SatW-1:0] a, input logic [rbp_pkg::SatW-1:0] b);
    logic [rbp_pkg::SatW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, rbp_pkg::SatMax}) ? rbp_pkg::SatMax : s[rbp_pkg::SatW-1:0];
  endfunction

  // Multiply a count by a small factor, clamp at the saturation bound
  function automatic logic [rbp_pkg::SatW-1:0] clamp_mul(
      input logic [rbp_pkg::SatW-1:0] a, input int unsigned k);
    logic [rbp_pkg::SatW+2:0] p;
    p = {3'b000, a} * (rbp_pkg::SatW+3)'(k);
    return (p > {3'b000, rbp_pkg::SatMax}) ? rbp_pkg::SatMax : p[rbp_pkg::SatW-1:0];
  endfunction

  // Step the mesh counts level by level and test both budgets at each level
  function automatic logic predict_fits(input logic                       tri_scheme,
                                        input logic [rbp_pkg::CountW-1:0] v0,
                                        input logic [rbp_pkg::CountW-1:0] e0,
                                        input logic [rbp_pkg::CountW-1:0] f0,
                                        input logic [rbp_pkg::CountW-1:0] fv0,
                                        input logic [rbp_pkg::LevelW-1:0] lvl,
                                        input logic [rbp_pkg::SatW-1:0]   v_lim,
                                        input logic [rbp_pkg::SatW-1:0]   f_lim);
    logic [rbp_pkg::SatW-1:0] v, e, f, fv, nv, ne, nf;
    int unsigned              depth;
    logic                     ok;
    v     = rbp_pkg::SatW'(v0);
    e     = rbp_pkg::SatW'(e0);
    f     = rbp_pkg::SatW'(f0);
    fv    = rbp_pkg::SatW'(fv0);
    depth = (lvl > MAX_LEVEL) ? MAX_LEVEL : lvl;
    ok    = 1'b1;
    for (int unsigned i = 0; i < depth && ok; i++) begin
      if (tri_scheme) begin
        nv = clamp_sum(v, e);
        ne = clamp_sum(clamp_mul(e, 2), clamp_mul(f, 3));
        nf = clamp_mul(f, 4);
      end else begin
        nv = clamp_sum(clamp_sum(v, e), f);
        nf = fv;
        ne = clamp_sum(clamp_mul(e, 2), nf);
      end
      v  = nv;
      e  = ne;
      f  = nf;
      fv = clamp_mul(f, tri_scheme ? 3 : 4);
      if (v > v_lim || f > f_lim) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatches++;
  endtask

  // Track budgets, retire results, then queue the prediction for a new query
  always @(posedge clk_i or negedge rst_ni) begin
    logic expected;
    logic prediction;
    if (!rst_ni) begin
      vertex_limit = rbp_pkg::BudgetReset;
      face_limit   = rbp_pkg::BudgetReset;
      fits_expected_q.delete();
      mismatches   = 0;
      queued       = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == rbp_pkg::RegVertexBudget) begin
          vertex_limit = cfg_wdata_i;
        end else if (cfg_index_i == rbp_pkg::RegFaceBudget) begin
          face_limit = cfg_wdata_i;
        end
      end
      if (done_o) begin
        if (fits_expected_q.size() == 0) begin
          report_mismatch("result strobe with no transaction outstanding");
        end else begin
          expected = fits_expected_q.pop_front();
          if (fits_o !== expected) begin
            report_mismatch($sformatf("fits expected %0b got %0b", expected, fits_o));
          end
        end
      end
      if (start && !busy) begin
        prediction = predict_fits(scheme_is_triangle_i, vertex_count_i,
                                  edge_count_i, face_count_i,
                                  corner_total_i, level_i,
                                  vertex_limit, face_limit);
        fits_expected_q = {fits_expected_q, prediction};
      end
      queued = fits_expected_q.size();
    end
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for refinement_budget_predictor
// Resets the block, runs directed queries at the count and level extremes
// and around the budget boundaries, then random queries under several budget
// settings with varying sender gaps. A side checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned SettleCycles  = 12;
  localparam int unsigned BlocksPerPhase = 6;
  localparam int unsigned ItemsPerBlock  = 30;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        start;
  logic                        busy;
  logic                        scheme_is_triangle_i;
  logic [rbp_pkg::CountW-1:0]  vertex_count_i;
  logic [rbp_pkg::CountW-1:0]  edge_count_i;
  logic [rbp_pkg::CountW-1:0]  face_count_i;
  logic [rbp_pkg::CountW-1:0]  corner_total_i;
  logic [rbp_pkg::LevelW-1:0]  level_i;
  logic                        done_o;
  logic                        fits_o;
  logic                        cfg_we_i;
  logic [rbp_pkg::CfgIdxW-1:0] cfg_index_i;
  logic [rbp_pkg::SatW-1:0]    cfg_wdata_i;
  int                          fail_count;
  int                          pending;
  int unsigned                 gap_pct;
  int unsigned                 stall_cycles;

  refinement_budget_predictor #(.MAX_LEVEL(8)) u_dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .start                (start),
    .busy                 (busy),
    .scheme_is_triangle_i (scheme_is_triangle_i),
    .vertex_count_i       (vertex_count_i),
    .edge_count_i         (edge_count_i),
    .face_count_i         (face_count_i),
    .corner_total_i       (corner_total_i),
    .level_i              (level_i),
    .done_o               (done_o),
    .fits_o               (fits_o),
    .cfg_we_i             (cfg_we_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_wdata_i          (cfg_wdata_i)
  );

  refinement_budget_checker #(.MAX_LEVEL(8)) u_checker (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .start                (start),
    .busy                 (busy),
    .scheme_is_triangle_i (scheme_is_triangle_i),
    .vertex_count_i       (vertex_count_i),
    .edge_count_i         (edge_count_i),
    .face_count_i         (face_count_i),
    .corner_total_i       (corner_total_i),
    .level_i              (level_i),
    .done_o               (done_o),
    .fits_o               (fits_o),
    .cfg_we_i             (cfg_we_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .fail_count_o         (fail_count),
    .pending_o            (pending)
  );

  // Free-running clock, 10 ns period
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o || cfg_we_i) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= WatchdogLimit) begin
      $display("refinement_budget_predictor test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Mix small, mid-range, random and all-ones counts
  function automatic logic [rbp_pkg::CountW-1:0] rand_count();
    case ($urandom_range(4))
      0: return rbp_pkg::CountW'($urandom_range(16));
      1: return rbp_pkg::CountW'($urandom_range(4000));
      2: return rbp_pkg::CountW'($urandom);
      3: return rbp_pkg::CountW'($urandom >> $urandom_range(31, 1));
      default: return {rbp_pkg::CountW{1'b1}};
    endcase
  endfunction

  // Spread budgets over all magnitudes, extremes included
  function automatic logic [rbp_pkg::SatW-1:0] rand_budget();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(5))
      0: return rbp_pkg::SatMax;
      1: return '0;
      2: return rbp_pkg::BudgetReset;
      default: return rbp_pkg::SatW'(r >> $urandom_range(63, 3));
    endcase
  endfunction

  // Present one query after a random gap, hold it until accepted
  task automatic send_query(input logic tri_scheme,
                            input logic [rbp_pkg::CountW-1:0] v,
                            input logic [rbp_pkg::CountW-1:0] e,
                            input logic [rbp_pkg::CountW-1:0] f,
                            input logic [rbp_pkg::CountW-1:0] fv,
                            input logic [rbp_pkg::LevelW-1:0] lvl);
    logic taken;
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start                <= 1'b1;
    scheme_is_triangle_i <= tri_scheme;
    vertex_count_i       <= v;
    edge_count_i         <= e;
    face_count_i         <= f;
    corner_total_i       <= fv;
    level_i              <= lvl;
    do begin
      @(negedge clk_i);
      taken = start && !busy;
      @(posedge clk_i);
    end while (!taken);
  endtask

  // Drop start and wait until every outstanding result has come back
  task automatic settle();
    start <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write both budgets on back-to-back edges
  task automatic write_budgets(input logic [rbp_pkg::SatW-1:0] v_lim,
                               input logic [rbp_pkg::SatW-1:0] f_lim);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= rbp_pkg::RegVertexBudget;
    cfg_wdata_i <= v_lim;
    @(posedge clk_i);
    cfg_index_i <= rbp_pkg::RegFaceBudget;
    cfg_wdata_i <= f_lim;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    logic [rbp_pkg::SatW-1:0] v_lim, f_lim;
    rst_ni               = 1'b0;
    start                = 1'b0;
    scheme_is_triangle_i = 1'b0;
    vertex_count_i       = '0;
    edge_count_i         = '0;
    face_count_i         = '0;
    corner_total_i       = '0;
    level_i              = '0;
    cfg_we_i             = 1'b0;
    cfg_index_i          = rbp_pkg::RegVertexBudget;
    cfg_wdata_i          = '0;
    gap_pct              = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset budgets, level zero, clamped level, all-ones counts
    send_query(1'b1, '0, '0, '0, '0, 4'd0);
    send_query(1'b0, '1, '1, '1, '1, 4'd0);
    send_query(1'b1, '1, '1, '1, '1, 4'd8);
    send_query(1'b0, '1, '1, '1, '1, 4'd15);
    send_query(1'b1, 31'd1, 31'd1, 31'd1, 31'd3, 4'd1);
    send_query(1'b0, 31'd8, 31'd12, 31'd6, 31'd24, 4'd2);
    send_query(1'b0, 31'd8, 31'd12, 31'd6, 31'd24, 4'd15);
    send_query(1'b1, '0, '0, '0, '0, 4'd8);

    // Directed: budgets exactly at, and just under, the level-one counts
    settle();
    write_budgets(61'd2, 61'd4);
    send_query(1'b1, 31'd1, 31'd1, 31'd1, 31'd3, 4'd1);
    send_query(1'b1, 31'd1, 31'd1, 31'd1, 31'd3, 4'd2);
    settle();
    write_budgets(61'd1, 61'd4);
    send_query(1'b1, 31'd1, 31'd1, 31'd1, 31'd3, 4'd1);
    settle();
    write_budgets(61'd2, 61'd3);
    send_query(1'b1, 31'd1, 31'd1, 31'd1, 31'd3, 4'd1);

    // Directed: zero budgets and budgets at the saturation bound
    settle();
    write_budgets('0, '0);
    send_query(1'b1, '0, '0, '0, '0, 4'd8);
    send_query(1'b0, '1, '1, '1, '1, 4'd0);
    settle();
    write_budgets(rbp_pkg::SatMax, rbp_pkg::SatMax);
    send_query(1'b1, '1, '1, '1, '1, 4'd8);
    send_query(1'b0, '1, '1, '1, '1, 4'd15);
    settle();

    // Random: three gap profiles, several budget settings in each
    for (int unsigned phase = 0; phase < 3; phase++) begin
      gap_pct = (phase == 0) ? 36 : (phase == 1) ? 61 : 0;
      for (int unsigned blk = 0; blk < BlocksPerPhase; blk++) begin
        case (blk)
          0: begin
            v_lim = rbp_pkg::SatMax;
            f_lim = rbp_pkg::SatMax;
          end
          1: begin
            v_lim = '0;
            f_lim = rbp_pkg::SatMax;
          end
          2: begin
            v_lim = rbp_pkg::SatMax;
            f_lim = '0;
          end
          default: begin
            v_lim = rand_budget();
            f_lim = rand_budget();
          end
        endcase
        write_budgets(v_lim, f_lim);
        for (int unsigned n = 0; n < ItemsPerBlock; n++) begin
          send_query(1'($urandom_range(1)), rand_count(), rand_count(), rand_count(),
                     rand_count(), rbp_pkg::LevelW'($urandom_range(15)));
        end
        settle();
      end
    end

    if (fail_count == 0 && pending == 0) begin
      $display("refinement_budget_predictor test passed");
    end else begin
      $display("refinement_budget_predictor test failed");
    end
    $finish;
  end

endmodule
